// File: rtl/ttb_pkg.sv
// shared types, codes and defaults for the timeout timer bank
package ttb_pkg;

    localparam int TIMERS_DEFAULT = 8;

    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 8;
    localparam int DURATION_W = 32;
    localparam int STATUS_W   = 3;
    localparam int TIME_W     = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RUNNING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd5;

    typedef struct packed {
        logic capture;
        logic execute;
    } ttb_cmd_t;

endpackage

// File: rtl/ttb_datapath.sv
// timer bank datapath: item registers, timer stores, time counter and status
module ttb_datapath #(
    parameter int TIMERS = ttb_pkg::TIMERS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttb_pkg::ttb_cmd_t             cmd,
    input  logic [ttb_pkg::FUNC_W-1:0]     in_func,
    input  logic [ttb_pkg::INDEX_W-1:0]    in_index,
    input  logic [ttb_pkg::DURATION_W-1:0] in_duration,
    input  logic                          in_reload,
    output logic [ttb_pkg::STATUS_W-1:0]   status
);
    import ttb_pkg::*;

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam logic [INDEX_W-1:0] TIMERS_LIMIT = INDEX_W'(TIMERS);

    logic [TIME_W-1:0]     stamp_mem [TIMERS];
    logic [DURATION_W-1:0] length_mem [TIMERS];

    logic [FUNC_W-1:0]     func_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [DURATION_W-1:0] duration_reg;
    logic                  reload_reg;
    logic [TIME_W-1:0]     stamp_rd_reg;
    logic [DURATION_W-1:0] length_rd_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [TIME_W-1:0]     time_reg;
    logic [TIME_W-1:0]     time_next;
    logic [TIMERS-1:0]     running_reg;
    logic [TIMERS-1:0]     running_next;

    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  tidx;
    logic              in_range;
    logic              run;
    logic              arm;
    logic [TIME_W-1:0] elapsed;

    assign rd_addr  = in_index[IDX_W-1:0];
    assign tidx     = index_reg[IDX_W-1:0];
    assign in_range = index_reg < TIMERS_LIMIT;
    assign run      = running_reg[tidx];
    assign elapsed  = time_reg - stamp_rd_reg;

    always_comb
    begin
        time_next    = time_reg;
        running_next = running_reg;
        status_next  = ST_OK;
        arm          = 1'b0;
        case (func_reg)
            FUNC_TICK:
            begin
                time_next = time_reg + TIME_W'(1);
            end
            FUNC_START:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else if (run && !reload_reg)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    arm                = 1'b1;
                    running_next[tidx] = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else if (!run)
                begin
                    status_next = ST_IDLE;
                end
                else if (elapsed < length_rd_reg)
                begin
                    status_next = ST_RUNNING;
                end
                else
                begin
                    status_next        = ST_EXPIRED;
                    running_next[tidx] = 1'b0;
                end
            end
            FUNC_STOP:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    running_next[tidx] = 1'b0;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= in_func;
            index_reg     <= in_index;
            duration_reg  <= in_duration;
            reload_reg    <= in_reload;
            stamp_rd_reg  <= stamp_mem[rd_addr];
            length_rd_reg <= length_mem[rd_addr];
        end
        if (cmd.execute && arm)
        begin
            stamp_mem[tidx]  <= time_reg;
            length_mem[tidx] <= duration_reg;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= '0;
            running_reg <= '0;
        end
        else if (cmd.execute)
        begin
            time_reg    <= time_next;
            running_reg <= running_next;
        end
    end

    assign status = status_reg;

endmodule

// File: rtl/ttb_controller.sv
// timer bank controller: accept, execute and send sequencing
module ttb_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ttb_pkg::ttb_cmd_t cmd
);
    import ttb_pkg::*;

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_EXEC,
        S_SEND
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_comb
    begin
        cmd.capture = s_tvalid && s_tready_reg;
        cmd.execute = (state_reg == S_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_ACCEPT;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_ACCEPT:
                begin
                    if (s_tvalid && s_tready_reg)
                    begin
                        state_reg    <= S_EXEC;
                        s_tready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    state_reg    <= S_SEND;
                    m_tvalid_reg <= 1'b1;
                end
                S_SEND:
                begin
                    if (m_tready)
                    begin
                        state_reg    <= S_ACCEPT;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_ACCEPT;
                    s_tready_reg <= 1'b1;
                    m_tvalid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// File: rtl/timeout_timer_bank_core.sv
// timeout timer bank top level: controller plus datapath
//
// a bank of TIMERS one-shot timeout timers on a shared 32-bit millisecond count
// input stream (s_*): one word per command; tuser carries the operation
// (tick, start, query, stop), tdata the timer index, duration and reload flag
// output stream (m_*): exactly one status word per input word, in order
// an accepted word is captured into the item registers and the store read
// registers; the single execute step then registers the status and raises
// m_tvalid; the block handles one word at a time and takes no new word until
// the status word of the last one has been delivered
// reset clears the time count and all running flags; the stamp and length
// stores need no clearing, they are only read for a running timer
// when the receiver stalls the status word holds in its register and no new
// input word is taken until it is delivered
module timeout_timer_bank_core #(
    parameter int TIMERS = ttb_pkg::TIMERS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // timer_index [7:0], duration [39:8], reload [40], zero fill
    input  logic [ttb_pkg::IN_DATA_W-1:0]   s_tdata,
    // func [1:0]
    input  logic [ttb_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [2:0], zero fill
    output logic [ttb_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import ttb_pkg::*;

    ttb_cmd_t            cmd;
    logic [STATUS_W-1:0] status;

    ttb_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ttb_datapath #(
        .TIMERS (TIMERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_func     (s_tuser),
        .in_index    (s_tdata[INDEX_W-1:0]),
        .in_duration (s_tdata[INDEX_W+DURATION_W-1:INDEX_W]),
        .in_reload   (s_tdata[INDEX_W+DURATION_W]),
        .status      (status)
    );

    assign m_tdata = {(OUT_DATA_W-STATUS_W)'(0), status};

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a status word is pending");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("status word not valid two cycles after accept");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_IDLE))
        else $error("undefined status code");
`endif

endmodule
